FILE: rtl/cfo_corrected_channel_phase_estimator_core_defines.svh
// Assertion macros for the channel phase estimator core
`ifndef CFO_CORRECTED_CHANNEL_PHASE_ESTIMATOR_CORE_DEFINES_SVH
`define CFO_CORRECTED_CHANNEL_PHASE_ESTIMATOR_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define CPE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define CPE_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define CPE_ASSERT(lbl, clk, rstn, prop, msg)
`define CPE_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

FILE: rtl/cpe_pkg.sv
// Shared types, constants and tables for the channel phase estimator
package cpe_pkg;
  localparam int SeqMax = 1024;
  localparam int RefAw = $clog2(SeqMax);
  localparam int SampleBits = 16;
  localparam int CfgAw = 1;
  localparam int CfgDw = 32;
  localparam logic [CfgAw-1:0] CfgSeqLen = 1'b0;
  localparam logic [CfgAw-1:0] CfgTurnPerHz = 1'b1;
  localparam logic ActLoad = 1'b0;

  typedef struct packed {
    logic              action;
    logic [9:0]        ref_index;
    logic signed [15:0] sample_re;
    logic signed [15:0] sample_im;
    logic signed [23:0] cfo_hz;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] est_re;
    logic signed [15:0] est_im;
    logic               zero_corr;
  } out_item_t;

  function automatic logic [31:0] atan_turn(input logic [3:0] i);
    logic [31:0] r;
    unique case (i)
      4'd0:  r = 32'h20000000;
      4'd1:  r = 32'h12E4051D;
      4'd2:  r = 32'h09FB385B;
      4'd3:  r = 32'h051111D4;
      4'd4:  r = 32'h028B0D43;
      4'd5:  r = 32'h0145D7E1;
      4'd6:  r = 32'h00A2F61E;
      4'd7:  r = 32'h00517C55;
      4'd8:  r = 32'h0028BE53;
      4'd9:  r = 32'h00145F2E;
      4'd10: r = 32'h000A2F98;
      4'd11: r = 32'h000517CC;
      4'd12: r = 32'h00028BE6;
      4'd13: r = 32'h000145F3;
      4'd14: r = 32'h0000A2F9;
      default: r = 32'h0000517C;
    endcase
    return r;
  endfunction
endpackage

FILE: rtl/cpe_ram.sv
// Generic single-port-write, registered-read RAM
module cpe_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: rtl/cpe_cordic.sv
// Iterative CORDIC: rotation (NCO) and vectoring (angle)
module cpe_cordic (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        vec_i,
  input  logic [31:0] phase_i,
  input  logic signed [47:0] re_i,
  input  logic signed [47:0] im_i,
  output logic        done_o,
  output logic signed [15:0] cos_o,
  output logic signed [15:0] sin_o,
  output logic [31:0] angle_o
);
  import cpe_pkg::*;

  typedef enum logic [1:0] {StIdle, StNorm, StIter, StOut} state_e;
  state_e state_q;
  logic vec_q, neg_q;
  logic [3:0] it_q;
  logic signed [49:0] x_q, y_q;
  logic signed [32:0] z_q;
  logic [31:0] za_q;
  logic signed [49:0] dx, dy, ax, ay, m;
  logic signed [32:0] zs;
  logic [31:0] ph_f;
  logic signed [49:0] rc, rs, nc, ns;
  logic dir;

  always_comb begin
    ph_f = phase_i + 32'h80000000;
    dx = y_q >>> it_q;
    dy = x_q >>> it_q;
    ax = x_q < 0 ? -x_q : x_q;
    ay = y_q < 0 ? -y_q : y_q;
    m = ax > ay ? ax : ay;
    dir = vec_q ? (y_q < 0) : (z_q >= 0);
    zs = $signed({1'b0, atan_turn(it_q)});
    rc = (x_q + 50'sd16384) >>> 15;
    rs = (y_q + 50'sd16384) >>> 15;
    nc = neg_q ? -rc : rc;
    ns = neg_q ? -rs : rs;
  end

  function automatic logic signed [15:0] sat16(input logic signed [49:0] v);
    if (v > 50'sd32767) return 16'sh7FFF;
    if (v < -50'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      unique case (state_q)
        StIdle: if (start_i) begin
          vec_q <= vec_i;
          it_q <= '0;
          if (vec_i) begin
            x_q <= {{2{re_i[47]}}, re_i};
            y_q <= {{2{im_i[47]}}, im_i};
            state_q <= StNorm;
          end else begin
            x_q <= 50'sh26DD3B6A;
            y_q <= '0;
            neg_q <= (phase_i + 32'h40000000) >= 32'h80000000;
            z_q <= (phase_i + 32'h40000000) >= 32'h80000000 ?
                   {ph_f[31], ph_f} : {phase_i[31], phase_i};
            state_q <= StIter;
          end
        end
        StNorm: begin
          // scale by one step of two until magnitude sits in [2^28, 2^29)
          if (m >= 50'sd536870912) begin
            x_q <= x_q >>> 1;
            y_q <= y_q >>> 1;
          end else if (m < 50'sd268435456) begin
            x_q <= x_q <<< 1;
            y_q <= y_q <<< 1;
          end else begin
            if (x_q < 0) begin
              x_q <= -x_q;
              y_q <= -y_q;
              za_q <= 32'h80000000;
            end else begin
              za_q <= '0;
            end
            state_q <= StIter;
          end
        end
        StIter: begin
          if (vec_q) begin
            if (!dir) begin
              x_q <= x_q + dx; y_q <= y_q - dy; za_q <= za_q + atan_turn(it_q);
            end else begin
              x_q <= x_q - dx; y_q <= y_q + dy; za_q <= za_q - atan_turn(it_q);
            end
          end else begin
            if (dir) begin
              x_q <= x_q - dx; y_q <= y_q + dy; z_q <= z_q - zs;
            end else begin
              x_q <= x_q + dx; y_q <= y_q - dy; z_q <= z_q + zs;
            end
          end
          it_q <= it_q + 4'd1;
          if (it_q == 4'd15) state_q <= StOut;
        end
        default: begin
          cos_o <= sat16(nc);
          sin_o <= sat16(ns);
          angle_o <= za_q;
          done_o <= 1'b1;
          state_q <= StIdle;
        end
      endcase
    end
  end
endmodule

FILE: rtl/cfo_corrected_channel_phase_estimator_core.sv
// Channel phase estimator core: reference RAM, derotation, correlation, normalisation
//
// Input channel in_*: one transaction is either a reference load (action 0),
// written to the reference RAM, or a received sample (action 1).
// On the first sample of a vector the phase step is cfo_hz * turn_per_hz >> 16.
// Each sample passes through the phase step, the shared iterative CORDIC
// NCO (derotation at its end), a wait on the RAM read and the correlation
// multiply-accumulate; a new sample is taken only once the last one is through.
// After the last sample of a vector the sum is normalised one bit a cycle and
// its angle measured, then turned back into a unit vector by the NCO, and the
// result is loaded into out_*; when the correlation is zero, angle and NCO are
// skipped and a zero result with zero_corr set goes out.
// The out register holds the result until taken; a stalled receiver stalls
// the final step of a vector, and no loads or samples are taken meanwhile.
// Reset clears the vector state and restores seq_len 64 and the default
// turn_per_hz; reference RAM contents are undefined until loaded.
// Configuration writes (cfg_*) take effect at once and need no handshake.
`include "cfo_corrected_channel_phase_estimator_core_defines.svh"
module cfo_corrected_channel_phase_estimator_core (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  cpe_pkg::in_item_t       in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output cpe_pkg::out_item_t      out_data_o,
  input  logic                    cfg_we_i,
  input  logic [cpe_pkg::CfgAw-1:0] cfg_index_i,
  input  logic [cpe_pkg::CfgDw-1:0] cfg_data_i
);
  import cpe_pkg::*;

  typedef enum logic [3:0] {
    StIdle, StStep, StNco, StMul, StAcc, StAngle, StEst, StOut
  } state_e;

  state_e state_q;
  logic [10:0] seq_len_q, count_q;
  logic [31:0] tph_q, phase_q, step_q;
  logic signed [47:0] acc_re_q, acc_im_q;
  logic signed [15:0] xr_q, xi_q, dr_q, di_q;
  logic signed [23:0] cfo_q;
  logic first_q;
  logic busy_q;
  out_item_t res_q;

  logic ram_we;
  logic [31:0] ram_rdata;
  logic cs_start, cs_vec, cs_done;
  logic signed [15:0] cs_cos, cs_sin;
  logic [31:0] cs_angle;
  logic accept;
  logic out_load;
  logic signed [32:0] sr_w, si_w;
  logic signed [15:0] rr, ri;
  logic signed [47:0] t_re, t_im;
  logic [10:0] cnt_inc, len_eff;
  logic signed [55:0] step_prod;

  assign accept = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == StIdle);
  assign ram_we = accept && (in_data_i.action == ActLoad);
  assign cs_start = (state_q == StNco) || (state_q == StAngle) || (state_q == StEst);
  assign cs_vec = (state_q == StAngle);
  assign out_load = (state_q == StOut) && (!out_valid_o || out_ready_i);

  cpe_ram #(.Width(32), .Depth(SeqMax)) u_ref_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (in_data_i.ref_index[RefAw-1:0]),
    .wdata_i ({in_data_i.sample_re, in_data_i.sample_im}),
    .raddr_i (count_q[RefAw-1:0]),
    .rdata_o (ram_rdata)
  );

  cpe_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cs_start && !busy_q),
    .vec_i   (cs_vec),
    .phase_i (state_q == StEst ? cs_angle : phase_q),
    .re_i    (acc_re_q),
    .im_i    (acc_im_q),
    .done_o  (cs_done),
    .cos_o   (cs_cos),
    .sin_o   (cs_sin),
    .angle_o (cs_angle)
  );

  function automatic logic signed [15:0] satw(input logic signed [32:0] v);
    logic signed [32:0] r;
    r = (v + 33'sd16384) >>> 15;
    if (r > 33'sd32767) return 16'sh7FFF;
    if (r < -33'sd32768) return 16'sh8000;
    return r[15:0];
  endfunction

  always_comb begin
    sr_w = 33'(xr_q * cs_cos) - 33'(xi_q * cs_sin);
    si_w = 33'(xr_q * cs_sin) + 33'(xi_q * cs_cos);
    rr = ram_rdata[31:16];
    ri = ram_rdata[15:0];
    t_re = 48'(dr_q * rr) + 48'(di_q * ri);
    t_im = 48'(dr_q * ri) - 48'(di_q * rr);
    cnt_inc = count_q + 11'd1;
    len_eff = (seq_len_q == '0) ? 11'd1 : seq_len_q;
    step_prod = cfo_q * $signed({1'b0, tph_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_len_q <= 11'd64;
      tph_q <= 32'd281474977;
      state_q <= StIdle;
      count_q <= '0;
      phase_q <= '0;
      step_q <= '0;
      acc_re_q <= '0;
      acc_im_q <= '0;
      out_valid_o <= 1'b0;
      busy_q <= 1'b0;
      first_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CfgSeqLen:    seq_len_q <= cfg_data_i[10:0];
          CfgTurnPerHz: tph_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_o <= 1'b1;
        out_data_o <= res_q;
      end else if (out_valid_o && out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      if (cs_start && !busy_q) busy_q <= 1'b1;
      if (cs_done) busy_q <= 1'b0;
      unique case (state_q)
        StIdle: if (accept && in_data_i.action != ActLoad) begin
          xr_q <= in_data_i.sample_re;
          xi_q <= in_data_i.sample_im;
          cfo_q <= in_data_i.cfo_hz;
          first_q <= (count_q == '0);
          state_q <= StStep;
        end
        StStep: begin
          // latch the phase step at the head of a vector
          if (first_q) begin
            step_q <= step_prod[47:16];
            phase_q <= '0;
          end
          state_q <= StNco;
        end
        StNco: if (cs_done) begin
          dr_q <= satw(sr_w);
          di_q <= satw(si_w);
          phase_q <= phase_q + step_q;
          state_q <= StMul;
        end
        StMul: state_q <= StAcc;
        StAcc: begin
          count_q <= cnt_inc;
          if (cnt_inc != '0 && cnt_inc < len_eff) begin
            acc_re_q <= acc_re_q + t_re;
            acc_im_q <= acc_im_q + t_im;
            state_q <= StIdle;
          end else if ((acc_re_q + t_re) == '0 && (acc_im_q + t_im) == '0) begin
            res_q <= '{est_re: '0, est_im: '0, zero_corr: 1'b1};
            acc_re_q <= '0;
            acc_im_q <= '0;
            state_q <= StOut;
          end else begin
            acc_re_q <= acc_re_q + t_re;
            acc_im_q <= acc_im_q + t_im;
            state_q <= StAngle;
          end
        end
        StAngle: if (cs_done) state_q <= StEst;
        StEst: if (cs_done) begin
          res_q <= '{est_re: cs_cos, est_im: cs_sin, zero_corr: 1'b0};
          acc_re_q <= '0;
          acc_im_q <= '0;
          state_q <= StOut;
        end
        default: if (out_load) begin
          count_q <= '0;
          phase_q <= '0;
          state_q <= StIdle;
        end
      endcase
    end
  end

  `CPE_ASSERT(a_no_accept_busy, clk_i, rst_ni, (state_q != StIdle) |-> !in_ready_o, "accept while busy")
  `CPE_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_o && !out_ready_i) |=> out_valid_o, "result dropped")
  `CPE_ASSERT(a_zero_flag, clk_i, rst_ni, (out_valid_o && out_data_o.zero_corr) |-> (out_data_o.est_re == '0 && out_data_o.est_im == '0), "zero flag with data")
endmodule
